### rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// This package holds the action codes, the status codes and the default depth
// that the queue and its storage share.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEQ_DEPTH_DEFAULT = 128;
  localparam int DATA_W            = 32;
  localparam int ACTION_W          = 4;
  localparam int STATUS_W          = 2;

  // Action codes carried by an input transaction.
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_REVERSE    = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_SORT       = 4'd8;

  // Status codes returned with every result.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

endpackage

### rtl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue storage
// Simple dual-port memory with one write port and one read port. Read data is
// registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module deq_ram
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Sequence: push, clear, a failed pop or peek and unused codes load the result
//   from idle; pop and peek pass through S_READ (memory read). Reverse runs
//   S_RV_A to S_RV_D per swapped pair; sort runs bubble passes over the single
//   read and write port, each pass from S_SO_INIT through S_SO_CMP to S_SO_END.
// Throughput: one transaction per result, taken in idle with no stalled result.
// Reset (rst, synchronous): empty queue, head at zero; stored words are kept.
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring buffer of signed words in one memory with push, pop and peek at both
// ends, clear, in-place reverse and in-place ascending sort.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACTION_W-1:0]        action,
  input  logic signed [DATA_W-1:0]   data_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   data_out,
  output logic [STATUS_W-1:0]        status,
  output logic [CW-1:0]              count,
  output logic                       is_empty
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_READ    = 4'd1;
  localparam logic [3:0] S_RV_A    = 4'd2;
  localparam logic [3:0] S_RV_B    = 4'd3;
  localparam logic [3:0] S_RV_C    = 4'd4;
  localparam logic [3:0] S_RV_D    = 4'd5;
  localparam logic [3:0] S_SO_INIT = 4'd6;
  localparam logic [3:0] S_SO_LOAD = 4'd7;
  localparam logic [3:0] S_SO_RD   = 4'd8;
  localparam logic [3:0] S_SO_CMP  = 4'd9;
  localparam logic [3:0] S_SO_END  = 4'd10;

  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [3:0]        state;
  logic [AW-1:0]     head;
  logic [CW-1:0]     entry_count;
  logic [AW-1:0]     lo;
  logic [AW-1:0]     hi;
  logic [AW-1:0]     j;
  logic [AW-1:0]     lim;
  logic [DATA_W-1:0] hold;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              in_accept;
  logic              full;
  logic              empty;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     last_off;
  logic              rd_less;
  logic              rv_more;
  logic              res_load;

  // Physical slot of an offset from the front entry.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign full      = (entry_count == CNT_FULL);
  assign empty     = (entry_count == '0);
  assign head_dec  = (head == '0) ? LAST_IDX : head - 1'b1;
  assign last_off  = AW'(entry_count - 1'b1);
  assign rd_less   = $signed(mem_rdata) < $signed(hold);
  assign rv_more   = ({1'b0, lo} + (AW + 1)'(2)) < {1'b0, hi};

  deq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Memory port control for each state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = head;
    mem_wdata = data_in;
    mem_raddr = head;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (action)
            ACT_PUSH_FRONT: begin
              mem_we    = !full;
              mem_waddr = head_dec;
            end
            ACT_PUSH_BACK: begin
              mem_we    = !full;
              mem_waddr = slot_of(head, entry_count[AW-1:0]);
            end
            ACT_POP_BACK, ACT_PEEK_BACK: begin
              mem_raddr = slot_of(head, last_off);
            end
            default: begin
              mem_raddr = head;
            end
          endcase
        end
      end
      S_RV_A: mem_raddr = slot_of(head, lo);
      S_RV_B: mem_raddr = slot_of(head, hi);
      S_RV_C: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head, lo);
        mem_wdata = mem_rdata;
      end
      S_RV_D: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head, hi);
        mem_wdata = hold;
      end
      S_SO_INIT: mem_raddr = head;
      S_SO_LOAD, S_SO_RD: mem_raddr = slot_of(head, j);
      S_SO_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head, j - 1'b1);
        mem_wdata = rd_less ? mem_rdata : hold;
      end
      S_SO_END: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head, lim);
        mem_wdata = hold;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // A result is loaded when a short action is taken or a read or walk finishes.
  always_comb begin
    res_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (action)
            ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
              res_load = empty;
            end
            ACT_REVERSE, ACT_SORT: begin
              res_load = (entry_count <= CW'(1));
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ:   res_load = 1'b1;
      S_RV_D:   res_load = !rv_more;
      S_SO_END: res_load = (lim == AW'(1));
      default:  res_load = 1'b0;
    endcase
  end

  // Result valid: set when a result is loaded, cleared once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer, queue pointers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      entry_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            case (action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                data_out <= '0;
                if (full) begin
                  status   <= ST_OVERFLOW;
                  count    <= entry_count;
                  is_empty <= empty;
                end else begin
                  if (action == ACT_PUSH_FRONT) begin
                    head <= head_dec;
                  end
                  entry_count <= entry_count + 1'b1;
                  status      <= ST_OK;
                  count       <= entry_count + 1'b1;
                  is_empty    <= 1'b0;
                end
              end
              ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
                if (empty) begin
                  data_out <= '0;
                  status   <= ST_EMPTY;
                  count    <= entry_count;
                  is_empty <= 1'b1;
                end else begin
                  state <= S_READ;
                  if (action == ACT_POP_FRONT) begin
                    head <= slot_of(head, AW'(1));
                  end
                  if (action == ACT_POP_FRONT || action == ACT_POP_BACK) begin
                    entry_count <= entry_count - 1'b1;
                  end
                end
              end
              ACT_CLEAR: begin
                head        <= '0;
                entry_count <= '0;
                data_out    <= '0;
                status      <= ST_OK;
                count       <= '0;
                is_empty    <= 1'b1;
              end
              ACT_REVERSE: begin
                if (entry_count > CW'(1)) begin
                  lo    <= '0;
                  hi    <= last_off;
                  state <= S_RV_A;
                end else begin
                  data_out <= '0;
                  status   <= ST_OK;
                  count    <= entry_count;
                  is_empty <= empty;
                end
              end
              ACT_SORT: begin
                if (entry_count > CW'(1)) begin
                  lim   <= last_off;
                  j     <= AW'(1);
                  state <= S_SO_INIT;
                end else begin
                  data_out <= '0;
                  status   <= ST_OK;
                  count    <= entry_count;
                  is_empty <= empty;
                end
              end
              default: begin
                data_out <= '0;
                status   <= ST_OK;
                count    <= entry_count;
                is_empty <= empty;
              end
            endcase
          end
        end
        S_READ: begin
          data_out <= mem_rdata;
          status   <= ST_OK;
          count    <= entry_count;
          is_empty <= empty;
          state    <= S_IDLE;
        end
        S_RV_A: state <= S_RV_B;
        S_RV_B: begin
          hold  <= mem_rdata;
          state <= S_RV_C;
        end
        S_RV_C: state <= S_RV_D;
        S_RV_D: begin
          lo <= lo + 1'b1;
          hi <= hi - 1'b1;
          if (rv_more) begin
            state <= S_RV_A;
          end else begin
            data_out <= '0;
            status   <= ST_OK;
            count    <= entry_count;
            is_empty <= empty;
            state    <= S_IDLE;
          end
        end
        S_SO_INIT: state <= S_SO_LOAD;
        S_SO_LOAD: begin
          hold  <= mem_rdata;
          state <= S_SO_CMP;
        end
        S_SO_RD: state <= S_SO_CMP;
        S_SO_CMP: begin
          // The larger word travels on toward the end of the pass.
          if (!rd_less) begin
            hold <= mem_rdata;
          end
          if (j == lim) begin
            state <= S_SO_END;
          end else begin
            j     <= j + 1'b1;
            state <= S_SO_RD;
          end
        end
        S_SO_END: begin
          if (lim == AW'(1)) begin
            data_out <= '0;
            status   <= ST_OK;
            count    <= entry_count;
            is_empty <= empty;
            state    <= S_IDLE;
          end else begin
            lim   <= lim - 1'b1;
            j     <= AW'(1);
            state <= S_SO_INIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill level never passes the ring size.
  assert property (@(posedge clk) disable iff (rst) entry_count <= CNT_FULL)
    else $error("entry count above depth");

  // A transaction is taken only when the result register can hold its result.
  assert property (@(posedge clk) disable iff (rst)
                   in_accept |-> !(out_valid && out_stall))
    else $error("transaction accepted while result register blocked");

  // The empty flag agrees with the reported count.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  // A failed pop or peek returns zero.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && status == ST_EMPTY) |-> (data_out == '0))
    else $error("nonzero data with empty status");

  // Reverse and sort leave the fill level alone.
  assert property (@(posedge clk) disable iff (rst)
                   (state != S_IDLE && state != S_READ) |=> $stable(entry_count))
    else $error("entry count changed during reorder");

endmodule
